// ----- hdl/edcl_pkg.sv -----
`timescale 1ns / 1ps

package edcl_pkg;

	localparam int SEQ_FIELD_W = 14;
	localparam int SEQ_CMP_W   = 16;
	localparam int SEQ_RESET   = 35;
	localparam int POS_W       = 11;
	localparam logic [POS_W-1:0] POS_MAX = '1;

	// received packet layout, byte positions
	localparam logic [POS_W-1:0] POS_CTRL_FIRST = 11'd2;
	localparam logic [POS_W-1:0] POS_CTRL_LAST  = 11'd5;
	localparam logic [POS_W-1:0] POS_ADDR_FIRST = 11'd6;
	localparam logic [POS_W-1:0] POS_ADDR_LAST  = 11'd9;
	localparam logic [POS_W-1:0] POS_DATA_FIRST = 11'd10;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	// response byte counter: header runs 0..9, a data word 2..5
	localparam logic [3:0] HDR_FIRST  = 4'd0;
	localparam logic [3:0] DATA_FIRST = 4'd2;
	localparam logic [3:0] DATA_END   = 4'd5;
	localparam logic [3:0] HDR_END    = 4'd9;

	typedef enum logic [1:0] {
		KIND_TX = 2'd0,
		KIND_RD = 2'd1,
		KIND_WR = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		BODY_NONE = 2'd0,
		BODY_HDR  = 2'd1,
		BODY_DATA = 2'd2
	} body_t;

	typedef enum logic [1:0] {
		PH_WR   = 2'd0,
		PH_BODY = 2'd1,
		PH_TAIL = 2'd2
	} phase_t;

	// one queued job: optional bus write, then header or data word, then read request or zeros
	typedef struct packed {
		logic        wr_en;
		logic [31:0] wr_addr;
		logic [31:0] wr_data;
		body_t       body;
		logic [31:0] body_word;
		logic [31:0] body_addr;
		logic        body_last;
		logic        tail_read;
		logic [31:0] tail_addr;
		logic [1:0]  zeros;
	} edcl_cmd_t;

endpackage

// ----- hdl/edcl_front.sv -----
`timescale 1ns / 1ps

module edcl_front #(
	parameter int SEQ_WIDTH = 14
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  logic                action,
	input  logic [7:0]          rx_byte,
	input  logic                rx_last,
	input  logic [31:0]         read_data,
	output logic                push,
	output edcl_pkg::edcl_cmd_t cmd
);
	import edcl_pkg::*;

	logic [SEQ_WIDTH-1:0] seq_q, seq_n;
	logic [POS_W-1:0]     pos_q, pos_n;
	logic [31:0]          ctrl_q, ctrl_n;
	logic [31:0]          addr_q, addr_n;
	logic [23:0]          asm_q, asm_n;
	logic [7:0]           wd_q, wd_n;
	logic                 rd_q, rd_n;
	logic                 rej_q, rej_n;

	logic                 has;
	logic [7:0]           wd_inc;
	logic                 fin;
	logic [1:0]           k;
	logic [SEQ_CMP_W-1:0] seq_ext;
	logic [9:0]           len;

	assign seq_ext = SEQ_CMP_W'(seq_q);
	assign push    = accept && has;

	always_comb begin
		seq_n  = seq_q;
		pos_n  = pos_q;
		ctrl_n = ctrl_q;
		addr_n = addr_q;
		asm_n  = asm_q;
		wd_n   = wd_q;
		rd_n   = rd_q;
		rej_n  = rej_q;
		cmd    = '0;
		cmd.body = BODY_NONE;
		has    = 1'b0;
		wd_inc = wd_q + 8'd1;
		fin    = wd_inc >= ctrl_q[16:9];
		k      = pos_q[1:0] + 2'd2;
		len    = 10'd0;
		if (action) begin
			if (rd_q) begin
				has           = 1'b1;
				cmd.body      = BODY_DATA;
				cmd.body_word = read_data;
				cmd.body_last = fin && (ctrl_q[8:7] == 2'd0);
				if (!fin) begin
					cmd.tail_read = 1'b1;
					cmd.tail_addr = addr_q + {22'd0, wd_inc, 2'b00};
					wd_n          = wd_inc;
				end else begin
					cmd.zeros = ctrl_q[8:7];
					rd_n      = 1'b0;
					wd_n      = 8'd0;
				end
			end
		end else if (!rd_q) begin
			if (pos_q >= POS_CTRL_FIRST && pos_q <= POS_CTRL_LAST) begin
				ctrl_n = {ctrl_q[23:0], rx_byte};
			end else if (pos_q >= POS_ADDR_FIRST && pos_q <= POS_ADDR_LAST) begin
				addr_n = {addr_q[23:0], rx_byte};
				if (pos_q == POS_ADDR_LAST) begin
					rej_n = SEQ_CMP_W'(ctrl_q[31:18]) != seq_ext;
					wd_n  = 8'd0;
				end
			end else if (pos_q >= POS_DATA_FIRST && !rej_q && ctrl_q[17]) begin
				if (k != 2'd3) begin
					asm_n = {asm_q[15:0], rx_byte};
				end else if (wd_q < ctrl_q[16:9]) begin
					has         = 1'b1;
					cmd.wr_en   = 1'b1;
					cmd.wr_addr = addr_q + {22'd0, wd_q, 2'b00};
					cmd.wr_data = {asm_q, rx_byte};
					wd_n        = wd_inc;
				end
			end

			if (rx_last) begin
				if (pos_q >= POS_ADDR_LAST) begin
					has           = 1'b1;
					cmd.body      = BODY_HDR;
					cmd.body_addr = addr_n;
					if (rej_n) begin
						// nak: expected sequence, zero length
						cmd.body_word = {seq_ext[SEQ_FIELD_W-1:0], 1'b1, 10'd0, ctrl_n[6:0]};
						cmd.body_last = 1'b1;
					end else begin
						len           = ctrl_n[16:7];
						cmd.body_word = {seq_ext[SEQ_FIELD_W-1:0], 1'b0, len, ctrl_n[6:0]};
						seq_n         = seq_q + 1'b1;
						if (ctrl_n[17]) begin
							cmd.body_last = 1'b1;
						end else begin
							cmd.body_last = len == 10'd0;
							if (ctrl_n[16:9] != 8'd0) begin
								cmd.tail_read = 1'b1;
								cmd.tail_addr = addr_n;
								rd_n          = 1'b1;
							end else begin
								cmd.zeros = ctrl_n[8:7];
							end
						end
					end
				end
				pos_n = '0;
				wd_n  = 8'd0;
				asm_n = 24'd0;
				rej_n = 1'b0;
			end else if (pos_q != POS_MAX) begin
				pos_n = pos_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q  <= SEQ_WIDTH'(SEQ_RESET);
			pos_q  <= '0;
			ctrl_q <= '0;
			addr_q <= '0;
			asm_q  <= '0;
			wd_q   <= '0;
			rd_q   <= 1'b0;
			rej_q  <= 1'b0;
		end else if (accept) begin
			seq_q  <= seq_n;
			pos_q  <= pos_n;
			ctrl_q <= ctrl_n;
			addr_q <= addr_n;
			asm_q  <= asm_n;
			wd_q   <= wd_n;
			rd_q   <= rd_n;
			rej_q  <= rej_n;
		end
	end

endmodule

// ----- hdl/edcl_cmd_fifo.sv -----
`timescale 1ns / 1ps

module edcl_cmd_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  edcl_pkg::edcl_cmd_t cmd_in,
	input  logic                pop,
	output edcl_pkg::edcl_cmd_t head,
	output logic                full,
	output logic                empty
);
	import edcl_pkg::*;

	edcl_cmd_t         mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;

	assign head  = mem_q[rd_ptr_q];
	assign full  = count_q == (QPTR_W+1)'(QUEUE_DEPTH);
	assign empty = count_q == '0;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- hdl/edcl_back.sv -----
`timescale 1ns / 1ps

module edcl_back (
	input  logic                clk,
	input  logic                arst_n,
	input  edcl_pkg::edcl_cmd_t head,
	input  logic                empty,
	output logic                pop,
	input  logic                out_ready,
	output logic                out_valid,
	output logic [1:0]          out_kind,
	output logic [7:0]          tx_byte,
	output logic                tx_last,
	output logic [31:0]         bus_address,
	output logic [31:0]         bus_write_data
);
	import edcl_pkg::*;

	logic        started_q;
	phase_t      phase_q;
	logic [3:0]  cnt_q;

	logic        out_valid_q;
	kind_t       kind_q;
	logic [7:0]  byte_q;
	logic        last_q;
	logic [31:0] addr_q;
	logic [31:0] data_q;

	phase_t      eff_phase, nxt_phase;
	logic [3:0]  eff_cnt, nxt_cnt, body_end;
	logic        tail_empty, final_item, advance;
	kind_t       kind_d;
	logic [7:0]  byte_d;
	logic        last_d;
	logic [31:0] addr_d;
	logic [31:0] data_d;

	assign tail_empty = !head.tail_read && (head.zeros == 2'd0);
	assign body_end   = (head.body == BODY_HDR) ? HDR_END : DATA_END;
	assign advance    = !empty && (!out_valid_q || out_ready);
	assign pop        = advance && final_item;

	always_comb begin
		if (started_q) begin
			eff_phase = phase_q;
			eff_cnt   = cnt_q;
		end else begin
			if (head.wr_en) begin
				eff_phase = PH_WR;
			end else if (head.body != BODY_NONE) begin
				eff_phase = PH_BODY;
			end else begin
				eff_phase = PH_TAIL;
			end
			eff_cnt = (!head.wr_en && head.body == BODY_DATA) ? DATA_FIRST : HDR_FIRST;
		end

		kind_d     = KIND_TX;
		byte_d     = 8'd0;
		last_d     = 1'b0;
		addr_d     = 32'd0;
		data_d     = 32'd0;
		final_item = 1'b1;
		nxt_phase  = eff_phase;
		nxt_cnt    = eff_cnt + 4'd1;

		case (eff_phase)
			PH_WR: begin
				kind_d     = KIND_WR;
				addr_d     = head.wr_addr;
				data_d     = head.wr_data;
				final_item = (head.body == BODY_NONE) && tail_empty;
				nxt_phase  = (head.body != BODY_NONE) ? PH_BODY : PH_TAIL;
				nxt_cnt    = (head.body == BODY_DATA) ? DATA_FIRST : HDR_FIRST;
			end
			PH_BODY: begin
				case (eff_cnt)
					4'd2:    byte_d = head.body_word[31:24];
					4'd3:    byte_d = head.body_word[23:16];
					4'd4:    byte_d = head.body_word[15:8];
					4'd5:    byte_d = head.body_word[7:0];
					4'd6:    byte_d = head.body_addr[31:24];
					4'd7:    byte_d = head.body_addr[23:16];
					4'd8:    byte_d = head.body_addr[15:8];
					4'd9:    byte_d = head.body_addr[7:0];
					default: byte_d = 8'd0;
				endcase
				last_d     = (eff_cnt == body_end) && head.body_last;
				final_item = (eff_cnt == body_end) && tail_empty;
				if (eff_cnt == body_end) begin
					nxt_phase = PH_TAIL;
					nxt_cnt   = 4'd0;
				end
			end
			PH_TAIL: begin
				if (head.tail_read) begin
					kind_d = KIND_RD;
					addr_d = head.tail_addr;
				end else begin
					// zero padding for leftover length bytes
					last_d     = eff_cnt[1:0] == (head.zeros - 2'd1);
					final_item = last_d;
				end
			end
			default: begin
				final_item = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q   <= 1'b0;
			phase_q     <= PH_WR;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
			started_q   <= !final_item;
			phase_q     <= nxt_phase;
			cnt_q       <= nxt_cnt;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			kind_q <= kind_d;
			byte_q <= byte_d;
			last_q <= last_d;
			addr_q <= addr_d;
			data_q <= data_d;
		end
	end

	assign out_valid      = out_valid_q;
	assign out_kind       = kind_q;
	assign tx_byte        = byte_q;
	assign tx_last        = last_q;
	assign bus_address    = addr_q;
	assign bus_write_data = data_q;

endmodule

// ----- hdl/edcl_link_engine.sv -----
`timescale 1ns / 1ps

// debug link engine, link side
// input channel (in_valid/in_ready): action 0 carries one received payload byte with
// rx_last on the final byte of a packet; action 1 carries one bus read word (read_data)
// output channel (out_valid/out_ready): out_kind 0 is a response byte (tx_byte, tx_last),
// 1 a bus read request, 2 a bus write request (bus_address, bus_write_data)
// the parser takes one transfer per cycle while in_ready is high and queues at most one
// job per transfer into a 4-deep job queue; the emitter turns each job into results, one
// per cycle unless out_ready stalls it; a header job is 10 results plus a read request or
// up to 3 zero bytes, a returned read word 4 plus a read request or up to 3 zero bytes,
// a write one (11 with a header), so the sustained input rate is set by the emitter when
// responses are long; a job enters the queue as its transfer is accepted, and its first
// result goes from queue head to the output register, which a stalled receiver holds;
// the queue then fills and in_ready drops after four pending jobs, with no transfer lost
// reset clears the parser, queue and output valid flag; expected sequence starts at 35

module edcl_link_engine #(
	parameter int SEQ_WIDTH = 14
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        action,
	input  logic [7:0]  rx_byte,
	input  logic        rx_last,
	input  logic [31:0] read_data,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  out_kind,
	output logic [7:0]  tx_byte,
	output logic        tx_last,
	output logic [31:0] bus_address,
	output logic [31:0] bus_write_data
);
	import edcl_pkg::*;

	logic      accept;
	logic      push, pop, full, empty;
	edcl_cmd_t cmd, head;

	assign in_ready = !full;
	assign accept   = in_valid && in_ready;

	edcl_front #(
		.SEQ_WIDTH(SEQ_WIDTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.action    (action),
		.rx_byte   (rx_byte),
		.rx_last   (rx_last),
		.read_data (read_data),
		.push      (push),
		.cmd       (cmd)
	);

	edcl_cmd_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.cmd_in (cmd),
		.pop    (pop),
		.head   (head),
		.full   (full),
		.empty  (empty)
	);

	edcl_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.head           (head),
		.empty          (empty),
		.pop            (pop),
		.out_ready      (out_ready),
		.out_valid      (out_valid),
		.out_kind       (out_kind),
		.tx_byte        (tx_byte),
		.tx_last        (tx_last),
		.bus_address    (bus_address),
		.bus_write_data (bus_write_data)
	);

endmodule
